// ===== hw/rtl/tiew_pkg.sv =====
`default_nettype none
package tiew_pkg;

  // fixed widths of the item fields
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IMM_W     = 32;
  localparam int unsigned OUT_VAL_W = 32;
  localparam int unsigned LAT_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // default parameter values
  localparam int unsigned NUM_REGS_DEF        = 8;
  localparam int unsigned ADDSUB_STATIONS_DEF = 3;
  localparam int unsigned MULDIV_STATIONS_DEF = 2;
  localparam int unsigned DATA_WIDTH_DEF      = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_LAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUL_LAT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_LAT = 2'd3;

  // latency reset values
  localparam logic [LAT_W-1:0] ADD_LAT_RST = 6'd2;
  localparam logic [LAT_W-1:0] SUB_LAT_RST = 6'd2;
  localparam logic [LAT_W-1:0] MUL_LAT_RST = 6'd8;
  localparam logic [LAT_W-1:0] DIV_LAT_RST = 6'd40;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic issue;
    logic dispatch;
    logic calc;
    logic wb;
  } tiew_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
  } tiew_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tomasulo_issue_execute_writeback.sv =====
`default_nettype none
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   cmd_i op_i dest_reg_i src1_reg_i src2_reg_i
//                                    src2_is_imm_i immediate_i
// out      out_valid_o / out_stall_i issued_o addsub_* muldiv_* div_by_zero_o idle_o
// cfg      cfg_we_i                  cfg_idx_i cfg_data_i
//
// One beat in is one machine tick and gives one beat out; the block takes no new beat
// until the tick has passed through issue, dispatch, calc and writeback, and calc waits
// longer when a divide completes in the tick, while the bit-serial divider steps.
// Reset clears stations, alias table and units; the register file holds 2*i.
// A held output beat stops the block in writeback until it is taken.
module tomasulo_issue_execute_writeback #(
  parameter int unsigned NUM_REGS        = tiew_pkg::NUM_REGS_DEF,
  parameter int unsigned ADDSUB_STATIONS = tiew_pkg::ADDSUB_STATIONS_DEF,
  parameter int unsigned MULDIV_STATIONS = tiew_pkg::MULDIV_STATIONS_DEF,
  parameter int unsigned DATA_WIDTH      = tiew_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               cmd_i,
  input  wire logic [tiew_pkg::OP_W-1:0]          op_i,
  input  wire logic [tiew_pkg::REG_IDX_W-1:0]     dest_reg_i,
  input  wire logic [tiew_pkg::REG_IDX_W-1:0]     src1_reg_i,
  input  wire logic [tiew_pkg::REG_IDX_W-1:0]     src2_reg_i,
  input  wire logic                               src2_is_imm_i,
  input  wire logic signed [tiew_pkg::IMM_W-1:0]  immediate_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    issued_o,
  output logic                                    addsub_done_o,
  output logic [tiew_pkg::REG_IDX_W-1:0]          addsub_reg_o,
  output logic signed [tiew_pkg::OUT_VAL_W-1:0]   addsub_value_o,
  output logic                                    addsub_wrote_reg_o,
  output logic                                    muldiv_done_o,
  output logic [tiew_pkg::REG_IDX_W-1:0]          muldiv_reg_o,
  output logic signed [tiew_pkg::OUT_VAL_W-1:0]   muldiv_value_o,
  output logic                                    muldiv_wrote_reg_o,
  output logic                                    div_by_zero_o,
  output logic                                    idle_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tiew_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tiew_pkg::LAT_W-1:0]         cfg_data_i
);

  tiew_pkg::tiew_cmd_t cmd;
  tiew_pkg::tiew_sts_t sts;

  tiew_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tiew_dp #(
    .NUM_REGS        (NUM_REGS),
    .ADDSUB_STATIONS (ADDSUB_STATIONS),
    .MULDIV_STATIONS (MULDIV_STATIONS),
    .DATA_WIDTH      (DATA_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .item_cmd_i         (cmd_i),
    .op_i               (op_i),
    .dest_reg_i         (dest_reg_i),
    .src1_reg_i         (src1_reg_i),
    .src2_reg_i         (src2_reg_i),
    .src2_is_imm_i      (src2_is_imm_i),
    .immediate_i        (immediate_i),
    .issued_o           (issued_o),
    .addsub_done_o      (addsub_done_o),
    .addsub_reg_o       (addsub_reg_o),
    .addsub_value_o     (addsub_value_o),
    .addsub_wrote_reg_o (addsub_wrote_reg_o),
    .muldiv_done_o      (muldiv_done_o),
    .muldiv_reg_o       (muldiv_reg_o),
    .muldiv_value_o     (muldiv_value_o),
    .muldiv_wrote_reg_o (muldiv_wrote_reg_o),
    .div_by_zero_o      (div_by_zero_o),
    .idle_o             (idle_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tiew_ctrl.sv =====
`default_nettype none
module tiew_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire tiew_pkg::tiew_sts_t sts_i,
  output tiew_pkg::tiew_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DISP,
    S_CALC,
    S_WB
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   wb_go;

  // output slot free for the next beat
  assign wb_go = (state_q == S_WB) && (!out_valid_q || !out_stall_i);

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.issue    = (state_q == S_ISSUE);
    cmd_o.dispatch = (state_q == S_DISP);
    cmd_o.calc     = (state_q == S_CALC);
    cmd_o.wb       = wb_go;
  end

  // next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ISSUE;
      S_ISSUE: state_d = S_DISP;
      S_DISP:  state_d = S_CALC;
      S_CALC:  if (!sts_i.div_busy) state_d = S_WB;
      S_WB: begin
        if (wb_go) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a new result beat only comes out of writeback
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WB))
    else $error("result beat without writeback");

  // an accepted item always moves on to issue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_ISSUE))
    else $error("accepted item skipped issue");

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result beat dropped");

endmodule
`default_nettype wire

// ===== hw/rtl/tiew_dp.sv =====
`default_nettype none
module tiew_dp #(
  parameter int unsigned NUM_REGS        = tiew_pkg::NUM_REGS_DEF,
  parameter int unsigned ADDSUB_STATIONS = tiew_pkg::ADDSUB_STATIONS_DEF,
  parameter int unsigned MULDIV_STATIONS = tiew_pkg::MULDIV_STATIONS_DEF,
  parameter int unsigned DATA_WIDTH      = tiew_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tiew_pkg::tiew_cmd_t                 cmd_i,
  output tiew_pkg::tiew_sts_t                      sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [tiew_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tiew_pkg::LAT_W-1:0]          cfg_data_i,
  input  wire logic                                item_cmd_i,
  input  wire logic [tiew_pkg::OP_W-1:0]           op_i,
  input  wire logic [tiew_pkg::REG_IDX_W-1:0]      dest_reg_i,
  input  wire logic [tiew_pkg::REG_IDX_W-1:0]      src1_reg_i,
  input  wire logic [tiew_pkg::REG_IDX_W-1:0]      src2_reg_i,
  input  wire logic                                src2_is_imm_i,
  input  wire logic signed [tiew_pkg::IMM_W-1:0]   immediate_i,
  output logic                                     issued_o,
  output logic                                     addsub_done_o,
  output logic [tiew_pkg::REG_IDX_W-1:0]           addsub_reg_o,
  output logic signed [tiew_pkg::OUT_VAL_W-1:0]    addsub_value_o,
  output logic                                     addsub_wrote_reg_o,
  output logic                                     muldiv_done_o,
  output logic [tiew_pkg::REG_IDX_W-1:0]           muldiv_reg_o,
  output logic signed [tiew_pkg::OUT_VAL_W-1:0]    muldiv_value_o,
  output logic                                     muldiv_wrote_reg_o,
  output logic                                     div_by_zero_o,
  output logic                                     idle_o
);

  localparam int unsigned ALL = ADDSUB_STATIONS + MULDIV_STATIONS;
  localparam int unsigned SW  = $clog2(ALL);
  localparam int unsigned TW  = $clog2(ALL + 1);
  localparam int unsigned RW  = $clog2(NUM_REGS);
  localparam int unsigned CW  = $clog2(DATA_WIDTH + 1);
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned LW  = tiew_pkg::LAT_W;
  localparam int unsigned IXW = tiew_pkg::REG_IDX_W;
  localparam int unsigned OVW = tiew_pkg::OUT_VAL_W;
  localparam int unsigned IMW = tiew_pkg::IMM_W;

  // register index folded into the file size
  function automatic logic [RW-1:0] ridx(input logic [IXW-1:0] x);
    logic [RW-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << IXW); k++) begin
      if (x == IXW'(k)) r = RW'(k % NUM_REGS);
    end
    return r;
  endfunction

  // latched item
  logic                 cmd_q;
  logic [1:0]           op_q;
  logic [IXW-1:0]       dest_q, src1_q, src2_q;
  logic                 imm_flag_q;
  logic [IMW-1:0]       imm_q;
  logic                 iss_found_q;

  // architectural state and stations
  logic [LW-1:0] lat_q [4];
  logic [DW-1:0] rv_q [NUM_REGS];
  logic [TW-1:0] alias_q [NUM_REGS];
  logic [ALL-1:0] busy_q;
  logic [1:0]    st_op_q [ALL];
  logic [RW-1:0] st_dest_q [ALL];
  logic [DW-1:0] st_v1_q [ALL];
  logic [DW-1:0] st_v2_q [ALL];
  logic [TW-1:0] st_t1_q [ALL];
  logic [TW-1:0] st_t2_q [ALL];

  // execution units
  logic          a_active_q, m_active_q;
  logic [SW-1:0] a_st_q, m_st_q;
  logic [LW-1:0] a_rem_q, m_rem_q;
  logic          a_cmp_q, m_cmp_q;
  logic [DW-1:0] prod_q;

  // divider
  logic [DW-1:0] dv_r_q, dv_q_q, dv_b_q;
  logic [CW-1:0] dv_cnt_q;
  logic          dv_neg_q, dv_zero_q;

  // ---------------- issue ----------------
  logic          iss_found;
  logic [SW-1:0] iss_slot;
  logic [RW-1:0] d_idx, r1_idx, r2_idx;
  logic [DW+IMW-1:0] imm_ext;

  always_comb begin
    iss_found = 1'b0;
    iss_slot  = '0;
    for (int i = ALL - 1; i >= 0; i--) begin
      if (((op_q[1] && i >= ADDSUB_STATIONS) || (!op_q[1] && i < ADDSUB_STATIONS))
          && !busy_q[i]) begin
        iss_found = 1'b1;
        iss_slot  = SW'(i);
      end
    end
  end

  assign d_idx   = ridx(dest_q);
  assign r1_idx  = ridx(src1_q);
  assign r2_idx  = ridx(src2_q);
  assign imm_ext = {{DW{imm_q[IMW-1]}}, imm_q};

  // ---------------- dispatch pick ----------------
  logic          a_pick_ok, m_pick_ok;
  logic [SW-1:0] a_pick, m_pick;
  logic [LW-1:0] a_lat, m_lat;

  always_comb begin
    a_pick_ok = 1'b0;
    a_pick    = '0;
    m_pick_ok = 1'b0;
    m_pick    = '0;
    for (int i = 0; i < ALL; i++) begin
      if (busy_q[i] && st_t1_q[i] == '0 && st_t2_q[i] == '0) begin
        if (i < ADDSUB_STATIONS) begin
          a_pick_ok = 1'b1;
          a_pick    = SW'(i);
        end else begin
          m_pick_ok = 1'b1;
          m_pick    = SW'(i);
        end
      end
    end
  end

  assign a_lat = (lat_q[st_op_q[a_pick]] == '0) ? LW'(1) : lat_q[st_op_q[a_pick]];
  assign m_lat = (lat_q[st_op_q[m_pick]] == '0) ? LW'(1) : lat_q[st_op_q[m_pick]];

  // ---------------- results ----------------
  logic [TW-1:0] a_tag, m_tag;
  logic [RW-1:0] a_dest, m_dest;
  logic [DW-1:0] a_res, m_res, dv_res;
  logic [DW-1:0] m_a, m_b, m_a_abs, m_b_abs;
  logic [2*DW-1:0] prod_full;
  logic [ALL-1:0] busy_after;

  assign a_tag  = TW'(a_st_q) + TW'(1);
  assign m_tag  = TW'(m_st_q) + TW'(1);
  assign a_dest = st_dest_q[a_st_q];
  assign m_dest = st_dest_q[m_st_q];
  assign a_res  = st_op_q[a_st_q][0] ? (st_v1_q[a_st_q] - st_v2_q[a_st_q])
                                     : (st_v1_q[a_st_q] + st_v2_q[a_st_q]);
  assign dv_res = dv_zero_q ? '0 : (dv_neg_q ? (~dv_q_q + DW'(1)) : dv_q_q);
  assign m_res  = st_op_q[m_st_q][0] ? dv_res : prod_q;

  assign m_a       = st_v1_q[m_st_q];
  assign m_b       = st_v2_q[m_st_q];
  assign m_a_abs   = m_a[DW-1] ? (~m_a + DW'(1)) : m_a;
  assign m_b_abs   = m_b[DW-1] ? (~m_b + DW'(1)) : m_b;
  assign prod_full = m_a * m_b;

  always_comb begin
    busy_after = busy_q;
    if (a_cmp_q) busy_after[a_st_q] = 1'b0;
    if (m_cmp_q) busy_after[m_st_q] = 1'b0;
  end

  // one restoring step of the divider
  logic [DW:0]   dv_sh;
  logic [DW+1:0] dv_diff;

  assign dv_sh   = {dv_r_q, dv_q_q[DW-1]};
  assign dv_diff = {1'b0, dv_sh} - {2'b00, dv_b_q};

  assign sts_o.div_busy = (dv_cnt_q != '0);

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q[tiew_pkg::CFG_ADD_LAT] <= tiew_pkg::ADD_LAT_RST;
      lat_q[tiew_pkg::CFG_SUB_LAT] <= tiew_pkg::SUB_LAT_RST;
      lat_q[tiew_pkg::CFG_MUL_LAT] <= tiew_pkg::MUL_LAT_RST;
      lat_q[tiew_pkg::CFG_DIV_LAT] <= tiew_pkg::DIV_LAT_RST;
      for (int r = 0; r < NUM_REGS; r++) begin
        rv_q[r]    <= DW'(2 * r);
        alias_q[r] <= '0;
      end
      busy_q <= '0;
      for (int i = 0; i < ALL; i++) begin
        st_op_q[i]   <= '0;
        st_dest_q[i] <= '0;
        st_v1_q[i]   <= '0;
        st_v2_q[i]   <= '0;
        st_t1_q[i]   <= '0;
        st_t2_q[i]   <= '0;
      end
      a_active_q <= 1'b0;
      m_active_q <= 1'b0;
      a_st_q     <= '0;
      m_st_q     <= '0;
      a_rem_q    <= '0;
      m_rem_q    <= '0;
      a_cmp_q    <= 1'b0;
      m_cmp_q    <= 1'b0;
      dv_cnt_q   <= '0;
    end else begin
      // latency registers
      if (cfg_we_i) lat_q[cfg_idx_i] <= cfg_data_i;

      // divider count
      if (dv_cnt_q != '0) dv_cnt_q <= dv_cnt_q - CW'(1);

      if (cmd_i.issue) begin
        // rename into the lowest free station of the group
        if (cmd_q && iss_found) begin
          busy_q[iss_slot]    <= 1'b1;
          st_op_q[iss_slot]   <= op_q;
          st_dest_q[iss_slot] <= d_idx;
          st_t1_q[iss_slot]   <= alias_q[r1_idx];
          st_v1_q[iss_slot]   <= rv_q[r1_idx];
          if (imm_flag_q) begin
            st_t2_q[iss_slot] <= '0;
            st_v2_q[iss_slot] <= imm_ext[DW-1:0];
          end else begin
            st_t2_q[iss_slot] <= alias_q[r2_idx];
            st_v2_q[iss_slot] <= rv_q[r2_idx];
          end
          alias_q[d_idx] <= TW'(iss_slot) + TW'(1);
        end
      end else if (cmd_i.dispatch) begin
        // add/sub unit: start, count down or finish
        a_cmp_q <= 1'b0;
        if (!a_active_q) begin
          if (a_pick_ok) begin
            a_active_q <= 1'b1;
            a_st_q     <= a_pick;
            a_rem_q    <= a_lat;
          end
        end else if (a_rem_q > LW'(1)) begin
          a_rem_q <= a_rem_q - LW'(1);
        end else begin
          a_rem_q <= '0;
          a_cmp_q <= 1'b1;
        end
        // mul/div unit
        m_cmp_q <= 1'b0;
        if (!m_active_q) begin
          if (m_pick_ok) begin
            m_active_q <= 1'b1;
            m_st_q     <= m_pick;
            m_rem_q    <= m_lat;
          end
        end else if (m_rem_q > LW'(1)) begin
          m_rem_q <= m_rem_q - LW'(1);
        end else begin
          m_rem_q <= '0;
          m_cmp_q <= 1'b1;
          if (st_op_q[m_st_q] == tiew_pkg::OP_DIV) dv_cnt_q <= CW'(DW);
        end
      end else if (cmd_i.wb) begin
        // free stations, retire to the file, broadcast on the result bus
        busy_q <= busy_after;
        if (a_cmp_q) a_active_q <= 1'b0;
        if (m_cmp_q) m_active_q <= 1'b0;
        for (int r = 0; r < NUM_REGS; r++) begin
          if (a_cmp_q && a_dest == RW'(r) && alias_q[r] == a_tag) begin
            rv_q[r]    <= a_res;
            alias_q[r] <= '0;
          end
          if (m_cmp_q && m_dest == RW'(r) && alias_q[r] == m_tag) begin
            rv_q[r]    <= m_res;
            alias_q[r] <= '0;
          end
        end
        for (int i = 0; i < ALL; i++) begin
          if (busy_after[i]) begin
            if (a_cmp_q && st_t1_q[i] == a_tag) begin
              st_v1_q[i] <= a_res;
              st_t1_q[i] <= '0;
            end else if (m_cmp_q && st_t1_q[i] == m_tag) begin
              st_v1_q[i] <= m_res;
              st_t1_q[i] <= '0;
            end
            if (a_cmp_q && st_t2_q[i] == a_tag) begin
              st_v2_q[i] <= a_res;
              st_t2_q[i] <= '0;
            end else if (m_cmp_q && st_t2_q[i] == m_tag) begin
              st_v2_q[i] <= m_res;
              st_t2_q[i] <= '0;
            end
          end
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  logic [RW+IXW-1:0] a_dest_ext, m_dest_ext;
  logic [DW+OVW-1:0] a_res_ext, m_res_ext;

  assign a_dest_ext = {{IXW{1'b0}}, a_dest};
  assign m_dest_ext = {{IXW{1'b0}}, m_dest};
  assign a_res_ext  = {{OVW{1'b0}}, a_res};
  assign m_res_ext  = {{OVW{1'b0}}, m_res};

  always_ff @(posedge clk_i) begin
    // item capture
    if (cmd_i.load) begin
      cmd_q      <= item_cmd_i;
      op_q       <= op_i;
      dest_q     <= dest_reg_i;
      src1_q     <= src1_reg_i;
      src2_q     <= src2_reg_i;
      imm_flag_q <= src2_is_imm_i;
      imm_q      <= immediate_i;
    end
    // divider set-up and steps
    if (cmd_i.dispatch) begin
      dv_r_q    <= '0;
      dv_q_q    <= m_a_abs;
      dv_b_q    <= m_b_abs;
      dv_neg_q  <= m_a[DW-1] ^ m_b[DW-1];
      dv_zero_q <= (m_b == '0);
    end else if (dv_cnt_q != '0) begin
      if (!dv_diff[DW+1]) begin
        dv_r_q <= dv_diff[DW-1:0];
        dv_q_q <= {dv_q_q[DW-2:0], 1'b1};
      end else begin
        dv_r_q <= dv_sh[DW-1:0];
        dv_q_q <= {dv_q_q[DW-2:0], 1'b0};
      end
    end
    // multiplier
    if (cmd_i.calc) prod_q <= prod_full[DW-1:0];
    // result beat
    if (cmd_i.wb) begin
      issued_o           <= cmd_q && iss_found_q;
      addsub_done_o      <= a_cmp_q;
      addsub_reg_o       <= a_cmp_q ? a_dest_ext[IXW-1:0] : '0;
      addsub_value_o     <= a_cmp_q ? a_res_ext[OVW-1:0] : '0;
      addsub_wrote_reg_o <= a_cmp_q && alias_q[a_dest] == a_tag;
      muldiv_done_o      <= m_cmp_q;
      muldiv_reg_o       <= m_cmp_q ? m_dest_ext[IXW-1:0] : '0;
      muldiv_value_o     <= m_cmp_q ? m_res_ext[OVW-1:0] : '0;
      muldiv_wrote_reg_o <= m_cmp_q && alias_q[m_dest] == m_tag;
      div_by_zero_o      <= m_cmp_q && st_op_q[m_st_q] == tiew_pkg::OP_DIV && dv_zero_q;
      idle_o             <= (busy_after == '0);
    end
  end

  // issue outcome, held for the result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) iss_found_q <= iss_found;
  end

  // a running unit always owns a busy station
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_active_q |-> busy_q[a_st_q])
    else $error("add/sub unit runs a free station");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_active_q |-> busy_q[m_st_q])
    else $error("mul/div unit runs a free station");

  // an issued instruction holds its station
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.issue && cmd_q && iss_found) |=> busy_q[$past(iss_slot)])
    else $error("issue did not claim its station");

endmodule
`default_nettype wire
